### src/u8s8mma_pkg.sv
// ----------------------------------------------------------------------------
// u8s8mma_pkg
// Shared sizes and types for the unsigned-by-signed byte matrix multiply
// accumulate block.
// ----------------------------------------------------------------------------
package u8s8mma_pkg;

   localparam int ROWS = 16;
   localparam int COLS = 16;

   localparam int ROWS_USED   = (ROWS < 1) ? 1 : ((ROWS > 16) ? 16 : ROWS);
   localparam int COLS_USED   = (COLS < 1) ? 1 : ((COLS > 16) ? 16 : COLS);
   localparam int HALVES      = (COLS_USED > 8) ? 2 : 1;
   localparam int LANES       = 8;
   localparam int NUM_RESULTS = ROWS_USED * HALVES;
   localparam int CNT_W       = $clog2(NUM_RESULTS + 1);

   localparam int SUM_W  = 32;
   localparam int BYTE_W = 8;
   localparam int SLICE_W = 16 * BYTE_W;

   typedef logic [SUM_W-1:0] acc_word_type;
   typedef logic [ROWS_USED-1:0][COLS_USED-1:0][SUM_W-1:0] acc_grid_type;
   typedef logic [LANES-1:0][SUM_W-1:0] lane_row_type;
   typedef logic [SLICE_W-1:0] slice_type;

   // Control from the top level to the multiply accumulate array.
   typedef struct packed {
      logic step;   // add the registered slice this cycle
      logic clear;  // the slice is the last one: restart from zero
   } mac_ctrl_type;

endpackage

### src/u8s8mma_mac_array.sv
// ----------------------------------------------------------------------------
// u8s8mma_mac_array
// Grid of byte multipliers and 32-bit accumulators. Each step adds the outer
// product of one A column and one B row; the running sums are also offered
// with the current product already added so the last slice can be captured.
// ----------------------------------------------------------------------------
module u8s8mma_mac_array (
   input  logic                        clock,
   input  logic                        reset,
   input  u8s8mma_pkg::mac_ctrl_type   ctrl,
   input  u8s8mma_pkg::slice_type      a_bytes,
   input  u8s8mma_pkg::slice_type      b_bytes,
   output u8s8mma_pkg::acc_grid_type   acc_sum
);
   import u8s8mma_pkg::*;

   acc_grid_type acc_ff;
   acc_grid_type acc_in;

   for (genvar r = 0; r < ROWS_USED; r++) begin : g_row
      for (genvar c = 0; c < COLS_USED; c++) begin : g_col
         logic signed [2*BYTE_W:0] prod;
         // A is unsigned: a zero bit in front makes it a nonnegative 9-bit operand.
         assign prod = $signed({1'b0, a_bytes[BYTE_W*r +: BYTE_W]})
                       * $signed(b_bytes[BYTE_W*c +: BYTE_W]);
         assign acc_sum[r][c] = acc_ff[r][c]
                                + {{(SUM_W-2*BYTE_W-1){prod[2*BYTE_W]}}, prod};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.step) begin
         acc_in = ctrl.clear ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

### src/u8_s8_matrix_multiply_accumulate_top.sv
// ----------------------------------------------------------------------------
// u8_s8_matrix_multiply_accumulate_top
// Streaming C = A x B with unsigned byte A, signed byte B and 32-bit sums.
// ----------------------------------------------------------------------------
// One k slice is taken per clock while no last slice waits. A slice is
// registered on acceptance and added into the 16 x 16 accumulator grid
// from that register, so the multiplier grid sets the rate at one slice
// per cycle while no last slice waits. A slice flagged last copies the
// finished sums into a drain bank and restarts the grid at zero; the bank
// then sends 32 transactions (row by row, column half 0 before 1), one per
// cycle while the output is not stalled, starting in the cycle after the
// copy. Slices of the next matrix keep flowing during the drain; only a
// further last slice waits in the input register until the bank is empty.
module u8_s8_matrix_multiply_accumulate_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [63:0]         req_a_rows_low,
   input  logic [63:0]         req_a_rows_high,
   input  logic [63:0]         req_b_cols_low,
   input  logic [63:0]         req_b_cols_high,
   input  logic                req_last_slice,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_out_row,
   output logic                rsp_col_half,
   output logic signed [31:0]  rsp_sum0,
   output logic signed [31:0]  rsp_sum1,
   output logic signed [31:0]  rsp_sum2,
   output logic signed [31:0]  rsp_sum3,
   output logic signed [31:0]  rsp_sum4,
   output logic signed [31:0]  rsp_sum5,
   output logic signed [31:0]  rsp_sum6,
   output logic signed [31:0]  rsp_sum7,
   output logic                rsp_final_result
);
   import u8s8mma_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic          in_last_ff;
   slice_type     a_ff, b_ff;
   logic          req_take, advance, drain_busy, rsp_take, load;
   mac_ctrl_type  mac_ctrl;
   acc_grid_type  acc_sum;

   lane_row_type  snap_ff [NUM_RESULTS];
   lane_row_type  snap_load [NUM_RESULTS];
   logic [CNT_W-1:0] remain_ff;
   logic [3:0]    row_ff;
   logic          half_ff;

   assign drain_busy = (remain_ff != '0);
   assign advance    = in_valid_ff && !(in_last_ff && drain_busy);
   assign req_stall  = in_valid_ff && !advance;
   assign req_take   = req_valid && !req_stall;
   assign load       = advance && in_last_ff;
   assign rsp_take   = rsp_valid && !rsp_stall;

   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ff       <= {req_a_rows_high, req_a_rows_low};
         b_ff       <= {req_b_cols_high, req_b_cols_low};
         in_last_ff <= req_last_slice;
      end
   end

   assign mac_ctrl.step  = advance;
   assign mac_ctrl.clear = in_last_ff;

   u8s8mma_mac_array u_mac_array (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_bytes (a_ff),
      .b_bytes (b_ff),
      .acc_sum (acc_sum)
   );

   // Drain bank layout: entry r*HALVES+h holds row r, column half h.
   // Columns beyond the matrix width read as zero.
   for (genvar r = 0; r < ROWS_USED; r++) begin : g_snap_row
      for (genvar h = 0; h < HALVES; h++) begin : g_snap_half
         for (genvar n = 0; n < LANES; n++) begin : g_snap_lane
            if (h * LANES + n < COLS_USED) begin : g_used
               assign snap_load[r*HALVES+h][n] = acc_sum[r][h*LANES+n];
            end else begin : g_unused
               assign snap_load[r*HALVES+h][n] = '0;
            end
         end
      end
   end

   // The bank is a shift line: the head entry is always the result on offer.
   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_RESULTS; s++) begin
         if (load) begin
            snap_ff[s] <= snap_load[s];
         end else if (rsp_take) begin
            snap_ff[s] <= (s == NUM_RESULTS - 1) ? '0 : snap_ff[(s + 1) % NUM_RESULTS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         row_ff    <= '0;
         half_ff   <= 1'b0;
      end else if (load) begin
         remain_ff <= CNT_W'(NUM_RESULTS);
         row_ff    <= '0;
         half_ff   <= 1'b0;
      end else if (rsp_take) begin
         remain_ff <= remain_ff - 1'b1;
         if (HALVES == 1 || half_ff) begin
            half_ff <= 1'b0;
            row_ff  <= row_ff + 1'b1;
         end else begin
            half_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = drain_busy;
   assign rsp_out_row      = row_ff;
   assign rsp_col_half     = half_ff;
   assign rsp_final_result = (remain_ff == CNT_W'(1));
   assign rsp_sum0         = $signed(snap_ff[0][0]);
   assign rsp_sum1         = $signed(snap_ff[0][1]);
   assign rsp_sum2         = $signed(snap_ff[0][2]);
   assign rsp_sum3         = $signed(snap_ff[0][3]);
   assign rsp_sum4         = $signed(snap_ff[0][4]);
   assign rsp_sum5         = $signed(snap_ff[0][5]);
   assign rsp_sum6         = $signed(snap_ff[0][6]);
   assign rsp_sum7         = $signed(snap_ff[0][7]);

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming u8 x s8 matrix multiply accumulate.
// A directed table covers byte extremes, long accumulations and the row and
// column mapping; random matrices with short and long k runs follow. Every
// accepted slice updates a local accumulator grid, and each slice flagged
// last queues the rows of C that must come out, which are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import u8s8mma_pkg::*;

   localparam int RANDOM_ITEMS = 145;
   localparam int CALM_ITEMS   = 30;
   localparam int DRAIN_WAIT   = 64;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DIRECTED_N   = 18;

   typedef struct packed {
      logic [63:0] a_lo;
      logic [63:0] a_hi;
      logic [63:0] b_lo;
      logic [63:0] b_hi;
      logic        last;
   } stim_type;

   // A row of the directed table; has_lit means every used entry of C is lit.
   typedef struct packed {
      logic [63:0]        a_lo;
      logic [63:0]        a_hi;
      logic [63:0]        b_lo;
      logic [63:0]        b_hi;
      logic               last;
      logic               has_lit;
      logic signed [31:0] lit;
   } table_row_type;

   typedef struct packed {
      logic [3:0]             row;
      logic                   half;
      logic [LANES-1:0][31:0] sum;
      logic                   final_flag;
   } c_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [63:0] req_a_rows_low;
   logic [63:0] req_a_rows_high;
   logic [63:0] req_b_cols_low;
   logic [63:0] req_b_cols_high;
   logic req_last_slice;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_out_row;
   logic rsp_col_half;
   logic signed [31:0] rsp_sum0, rsp_sum1, rsp_sum2, rsp_sum3;
   logic signed [31:0] rsp_sum4, rsp_sum5, rsp_sum6, rsp_sum7;
   logic rsp_final_result;

   logic          rsp_quiet = 1'b0;
   int            stall_hold = 0;
   int            err_count = 0;
   int            cycle_count = 0;
   logic [31:0]   c_acc [16][16];
   c_row_type     expected_rows [$];
   table_row_type directed_tbl [DIRECTED_N];

   u8_s8_matrix_multiply_accumulate_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_a_rows_low   (req_a_rows_low),
      .req_a_rows_high  (req_a_rows_high),
      .req_b_cols_low   (req_b_cols_low),
      .req_b_cols_high  (req_b_cols_high),
      .req_last_slice   (req_last_slice),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_row      (rsp_out_row),
      .rsp_col_half     (rsp_col_half),
      .rsp_sum0         (rsp_sum0),
      .rsp_sum1         (rsp_sum1),
      .rsp_sum2         (rsp_sum2),
      .rsp_sum3         (rsp_sum3),
      .rsp_sum4         (rsp_sum4),
      .rsp_sum5         (rsp_sum5),
      .rsp_sum6         (rsp_sum6),
      .rsp_sum7         (rsp_sum7),
      .rsp_final_result (rsp_final_result)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Output stall: random bursts between open stretches.
   always @(posedge clock) begin
      if (reset || rsp_quiet) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 30);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 17);
      end
   end

   // Adds the outer product of one slice into the local grid.
   task automatic mac_slice(input stim_type s);
      logic [127:0] a_all;
      logic [127:0] b_all;
      logic [31:0]  av;
      logic [31:0]  bv;
      a_all = {s.a_hi, s.a_lo};
      b_all = {s.b_hi, s.b_lo};
      for (int r = 0; r < ROWS_USED; r++) begin
         av = {24'b0, a_all[8*r +: 8]};
         for (int c = 0; c < COLS_USED; c++) begin
            bv = {{24{b_all[8*c+7]}}, b_all[8*c +: 8]};
            c_acc[r][c] = c_acc[r][c] + av * bv;
         end
      end
   endtask

   // Queues the rows of C and restarts the grid at zero.
   task automatic queue_product(input logic use_lit, input logic signed [31:0] lit);
      c_row_type e;
      int        col;
      for (int r = 0; r < ROWS_USED; r++) begin
         for (int h = 0; h < HALVES; h++) begin
            e.row  = 4'(r);
            e.half = 1'(h);
            for (int n = 0; n < LANES; n++) begin
               col = h * LANES + n;
               if (col >= COLS_USED)
                  e.sum[n] = '0;
               else
                  e.sum[n] = use_lit ? lit : c_acc[r][col];
            end
            e.final_flag = (r == ROWS_USED - 1) && (h == HALVES - 1);
            expected_rows.insert(expected_rows.size(), e);
         end
      end
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++)
            c_acc[r][c] = '0;
   endtask

   // Holds the slice on the port until it is taken. Valid stays high after.
   task automatic offer_slice(input stim_type s, input logic use_lit,
                              input logic signed [31:0] lit);
      req_valid       <= 1'b1;
      req_a_rows_low  <= s.a_lo;
      req_a_rows_high <= s.a_hi;
      req_b_cols_low  <= s.b_lo;
      req_b_cols_high <= s.b_hi;
      req_last_slice  <= s.last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      mac_slice(s);
      if (s.last)
         queue_product(use_lit, lit);
   endtask

   task automatic hold_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_bytes();
      logic [63:0] w;
      if ($urandom_range(0, 4) == 0) begin
         w = {$urandom, $urandom};
      end else begin
         for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 6))
               0:       w[8*k +: 8] = 8'h00;
               1:       w[8*k +: 8] = 8'hFF;
               2:       w[8*k +: 8] = 8'h80;
               3:       w[8*k +: 8] = 8'h7F;
               default: w[8*k +: 8] = 8'($urandom);
            endcase
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin : rsp_check
      c_row_type              want;
      logic [LANES-1:0][31:0] got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_sum7, rsp_sum6, rsp_sum5, rsp_sum4,
                rsp_sum3, rsp_sum2, rsp_sum1, rsp_sum0};
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected transaction, row %0d half %0d",
                     $time, rsp_out_row, rsp_col_half);
            err_count++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_out_row !== want.row) begin
               $display("%0t: out_row expected %0d actual %0d",
                        $time, want.row, rsp_out_row);
               err_count++;
            end
            if (rsp_col_half !== want.half) begin
               $display("%0t: col_half expected %0d actual %0d",
                        $time, want.half, rsp_col_half);
               err_count++;
            end
            for (int n = 0; n < LANES; n++) begin
               if (got[n] !== want.sum[n]) begin
                  $display("%0t: row %0d half %0d sum%0d expected %0d actual %0d",
                           $time, want.row, want.half, n,
                           $signed(want.sum[n]), $signed(got[n]));
                  err_count++;
               end
            end
            if (rsp_final_result !== want.final_flag) begin
               $display("%0t: final_result expected %0d actual %0d",
                        $time, want.final_flag, rsp_final_result);
               err_count++;
            end
         end
      end
   end

   initial begin
      stim_type s;
      int       sent;
      int       k_len;
      logic     paused;
      logic     late;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_a_rows_low  = '0;
      req_a_rows_high = '0;
      req_b_cols_low  = '0;
      req_b_cols_high = '0;
      req_last_slice  = 1'b0;
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++)
            c_acc[r][c] = '0;

      directed_tbl = '{
         // Right after reset, then single slices at the byte extremes.
         '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1, 32'sd0},
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1, -32'sd32640},
         '{'1, '1, {8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 32'sd32385},
         '{{8{8'h01}}, {8{8'h01}}, '1, '1, 1'b1, 1'b1, -32'sd1},
         '{64'h0, 64'h0, {8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 32'sd0},
         '{'1, '1, 64'h0, 64'h0, 1'b1, 1'b1, 32'sd0},
         // Four slices of the most negative product summed.
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b0, 1'b0, 32'sd0},
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b0, 1'b0, 32'sd0},
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b0, 1'b0, 32'sd0},
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1, -32'sd130560},
         '{'1, '1, {8{8'h7F}}, {8{8'h7F}}, 1'b0, 1'b0, 32'sd0},
         '{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1, -32'sd255},
         // Distinct bytes per row and column to pin down the mapping.
         '{64'h0807060504030201, 64'h100F0E0D0C0B0A09,
           64'hF8F9FAFBFCFDFEFF, 64'h0807060504030201, 1'b1, 1'b0, 32'sd0},
         '{64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00,
           64'h807F807F807F807F, 64'h7F807F807F807F80, 1'b0, 1'b0, 32'sd0},
         '{64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
           64'h5A5AA5A5C33C3CC3, 64'h8001FF7F00102040, 1'b0, 1'b0, 32'sd0},
         '{{8{8'hAA}}, {8{8'h55}}, {8{8'h55}}, {8{8'hAA}}, 1'b1, 1'b0, 32'sd0},
         '{64'h80, 64'h0, 64'h0, 64'h8000000000000000, 1'b1, 1'b0, 32'sd0},
         '{64'h0, 64'hFF00000000000000, 64'h01, 64'h0, 1'b1, 1'b0, 32'sd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_tbl[i]) begin
         s.a_lo = directed_tbl[i].a_lo;
         s.a_hi = directed_tbl[i].a_hi;
         s.b_lo = directed_tbl[i].b_lo;
         s.b_hi = directed_tbl[i].b_hi;
         s.last = directed_tbl[i].last;
         offer_slice(s, directed_tbl[i].has_lit, directed_tbl[i].lit);
         if ($urandom_range(0, 3) == 0)
            hold_sender($urandom_range(1, 18));
      end

      // Random matrices: mostly short k runs, now and then longer than a drain.
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         k_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                             : $urandom_range(1, 6);
         // The final run is cut short so the item count stays on target.
         if (k_len > RANDOM_ITEMS - sent)
            k_len = RANDOM_ITEMS - sent;
         for (int j = 0; j < k_len; j++) begin
            late = (RANDOM_ITEMS - sent) < CALM_ITEMS;
            if (late)
               rsp_quiet <= 1'b1;
            s.a_lo = rand_bytes();
            s.a_hi = rand_bytes();
            s.b_lo = rand_bytes();
            s.b_hi = rand_bytes();
            s.last = (j == k_len - 1);
            offer_slice(s, 1'b0, 32'sd0);
            sent++;
            if (!late && $urandom_range(0, 3) == 0)
               hold_sender($urandom_range(1, 18));
         end
         // Once, let the block drain completely before sending more.
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_rows.size() != 0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
src/u8s8mma_pkg.sv
src/u8s8mma_mac_array.sv
src/u8_s8_matrix_multiply_accumulate_top.sv
tb/tb_top.sv
